FILE: sv/utf8_cjk_break_opportunity_assert.svh
// Assertion macros for the UTF-8 CJK break opportunity block.
// Used by the port checker; expects aclk and aresetn in the scope of the use.
`ifndef UTF8_CJK_BREAK_OPPORTUNITY_ASSERT_SVH
`define UTF8_CJK_BREAK_OPPORTUNITY_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UCBO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define UCBO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: sv/ucbo_pkg.sv
// Shared types, constants and character class functions for the UTF-8 CJK
// break opportunity block. No dependencies.
package ucbo_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W = 21;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_FOUR = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

    localparam logic [CP_W-1:0] CP_TAB = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF = 21'h0000A;
    localparam logic [CP_W-1:0] CP_CR = 21'h0000D;
    localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
    localparam logic [CP_W-1:0] CP_NONE = 21'h00000;

    localparam int NO_START_N = 54;
    localparam logic [CP_W-1:0] NO_START_SET [NO_START_N] = '{
        21'h03001, 21'h03002, 21'h0FF0C, 21'h0FF0E, 21'h0FF01, 21'h0FF1F,
        21'h0FF1A, 21'h0FF1B, 21'h0300D, 21'h0300F, 21'h0FF09, 21'h0FF3D,
        21'h0FF5D, 21'h03015, 21'h03009, 21'h0300B, 21'h0201D, 21'h02019,
        21'h030FB, 21'h03005, 21'h0309D, 21'h0309E, 21'h030FC, 21'h030FD,
        21'h030FE, 21'h03041, 21'h03043, 21'h03045, 21'h03047, 21'h03049,
        21'h03063, 21'h03083, 21'h03085, 21'h03087, 21'h0308E, 21'h030A1,
        21'h030A3, 21'h030A5, 21'h030A7, 21'h030A9, 21'h030C3, 21'h030E3,
        21'h030E5, 21'h030E7, 21'h030EE, 21'h0002C, 21'h0002E, 21'h00021,
        21'h0003F, 21'h0003A, 21'h0003B, 21'h00029, 21'h0005D, 21'h0007D
    };

    localparam int NO_END_N = 13;
    localparam logic [CP_W-1:0] NO_END_SET [NO_END_N] = '{
        21'h0300C, 21'h0300E, 21'h0FF08, 21'h0FF3B, 21'h0FF5B, 21'h03014,
        21'h03008, 21'h0300A, 21'h0201C, 21'h02018, 21'h00028, 21'h0005B,
        21'h0007B
    };

    // One classified code point as it travels from the decoder to the
    // break logic.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_space;
        logic            is_cjk;
        logic            no_start;
        logic            no_end;
        logic            non_null;
        logic            run_start;
        logic            first_ok;
        logic            run_end;
    } cp_entry_t;

    function automatic logic is_cjk(input logic [CP_W-1:0] c);
        return c inside {[21'h03000:21'h030FF], [21'h03400:21'h04DBF],
                         [21'h04E00:21'h09FFF], [21'h0F900:21'h0FAFF],
                         [21'h0FF00:21'h0FF60], [21'h0FFE0:21'h0FFE6]};
    endfunction

    function automatic logic in_no_start(input logic [CP_W-1:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NO_START_N; k++) begin
            hit = hit | (NO_START_SET[k] == c);
        end
        return hit;
    endfunction

    function automatic logic in_no_end(input logic [CP_W-1:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NO_END_N; k++) begin
            hit = hit | (NO_END_SET[k] == c);
        end
        return hit;
    endfunction

endpackage

FILE: sv/utf8_cjk_break_opportunity.sv
// Top level of the UTF-8 CJK line-break opportunity finder.
// Depends on ucbo_pkg, ucbo_front, ucbo_queue and ucbo_back.
//
// Usage:
//   The input channel (s_*) takes one byte of UTF-8 text per request, with
//   run_start on the first byte of a text run and run_end on its last one.
//   The result channel (m_*) carries one request per decoded code point: the
//   value, whether it is whitespace, whether it opens a new unbreakable piece,
//   whether a line may begin at that piece and whether it ends its run.
//   A byte that completes a code point (or ends a run) is written into the
//   queue at the edge at which it is accepted; its result is loaded into the
//   output register from the queue once that register is empty or being taken.
//   Bytes are taken at one per cycle while the queue has room.
//   When the receiver stalls, the result register holds its request and the
//   queue (QUEUE_DEPTH entries) fills; s_ready falls only once it is full,
//   and rises again the cycle after the receiver takes the waiting result.
//   Reset (aresetn low, synchronous) empties the queue and the result
//   register and clears decoder, previous-character and piece state.
module utf8_cjk_break_opportunity #(
    parameter int QUEUE_DEPTH = ucbo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ucbo_pkg::BYTE_W-1:0]  s_text_byte,
    input  logic                         s_run_start,
    input  logic                         s_first_piece_may_start_line,
    input  logic                         s_run_end,
    input  logic                         s_valid,
    output logic                         s_ready,
    output logic [ucbo_pkg::CP_W-1:0]    m_code_point,
    output logic                         m_is_space,
    output logic                         m_starts_piece,
    output logic                         m_piece_may_start_line,
    output logic                         m_last_of_run,
    output logic                         m_valid,
    input  logic                         m_ready
);

    ucbo_pkg::cp_entry_t push_data;
    ucbo_pkg::cp_entry_t head;
    logic push, pop, not_empty, full, accept;

    // Every byte needs the queue to have room, whether or not it completes a
    // code point, so that decoder state only moves on accepted requests.
    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    ucbo_front u_front (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .accept                     (accept),
        .text_byte                  (s_text_byte),
        .run_start                  (s_run_start),
        .first_piece_may_start_line (s_first_piece_may_start_line),
        .run_end                    (s_run_end),
        .push                       (push),
        .push_data                  (push_data)
    );

    ucbo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    // The back end applies the run start carried with each code point, so a
    // run start on a byte that emits nothing still takes effect in order.
    ucbo_back u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .head                   (head),
        .not_empty              (not_empty),
        .pop                    (pop),
        .m_code_point           (m_code_point),
        .m_is_space             (m_is_space),
        .m_starts_piece         (m_starts_piece),
        .m_piece_may_start_line (m_piece_may_start_line),
        .m_last_of_run          (m_last_of_run),
        .m_valid                (m_valid),
        .m_ready                (m_ready)
    );

endmodule

FILE: sv/ucbo_front.sv
// Front end: lenient UTF-8 decoder and character classifier.
// Depends on ucbo_pkg; pushes classified code points into ucbo_queue.
module ucbo_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [ucbo_pkg::BYTE_W-1:0]  text_byte,
    input  logic                         run_start,
    input  logic                         first_piece_may_start_line,
    input  logic                         run_end,
    output logic                         push,
    output ucbo_pkg::cp_entry_t          push_data
);

    logic [ucbo_pkg::CP_W-1:0] part_reg, part_next;
    logic [1:0]                exp_reg, exp_next;
    logic                      start_pend_reg, start_pend_next;
    logic                      first_ok_reg, first_ok_next;

    logic [ucbo_pkg::CP_W-1:0] part_base;
    logic [1:0]                exp_base;
    logic [ucbo_pkg::CP_W-1:0] dec_cp;
    logic [1:0]                dec_exp;
    logic [1:0]                extra;
    logic [ucbo_pkg::BYTE_W-1:0] lead_bits;
    logic [ucbo_pkg::CP_W-1:0] eff;
    logic                      emit;

    always_comb begin
        // A run start drops any partial code point before the byte is taken.
        part_base = run_start ? '0 : part_reg;
        exp_base  = run_start ? 2'd0 : exp_reg;

        if (text_byte >= ucbo_pkg::LEAD_FOUR) begin
            extra = 2'd3;
        end else if (text_byte >= ucbo_pkg::LEAD_THREE) begin
            extra = 2'd2;
        end else begin
            extra = 2'd1;
        end
        lead_bits = text_byte & (ucbo_pkg::CONT_MASK >> extra);

        if (exp_base == 2'd0) begin
            if (text_byte < ucbo_pkg::ASCII_LIMIT) begin
                dec_cp  = {{(ucbo_pkg::CP_W-ucbo_pkg::BYTE_W){1'b0}}, text_byte};
                dec_exp = 2'd0;
            end else begin
                dec_cp  = {{(ucbo_pkg::CP_W-ucbo_pkg::BYTE_W){1'b0}}, lead_bits};
                dec_exp = extra;
            end
        end else begin
            dec_cp  = {part_base[ucbo_pkg::CP_W-7:0], text_byte[5:0]};
            dec_exp = exp_base - 2'd1;
        end

        emit = accept && ((dec_exp == 2'd0) || run_end);

        // CR and LF behave as a space for breaking.
        if ((dec_cp == ucbo_pkg::CP_LF) || (dec_cp == ucbo_pkg::CP_CR)) begin
            eff = ucbo_pkg::CP_SPACE;
        end else begin
            eff = dec_cp;
        end

        push_data.code_point = dec_cp;
        push_data.is_space   = (eff == ucbo_pkg::CP_SPACE) || (eff == ucbo_pkg::CP_TAB);
        push_data.is_cjk     = ucbo_pkg::is_cjk(eff);
        push_data.no_start   = ucbo_pkg::in_no_start(eff);
        push_data.no_end     = ucbo_pkg::in_no_end(eff);
        push_data.non_null   = (eff != ucbo_pkg::CP_NONE);
        push_data.run_start  = run_start || start_pend_reg;
        push_data.first_ok   = run_start ? first_piece_may_start_line : first_ok_reg;
        push_data.run_end    = run_end;
        push = emit;

        part_next       = part_reg;
        exp_next        = exp_reg;
        start_pend_next = start_pend_reg;
        first_ok_next   = first_ok_reg;
        if (accept) begin
            if (emit) begin
                part_next       = '0;
                exp_next        = 2'd0;
                start_pend_next = 1'b0;
            end else begin
                part_next = dec_cp;
                exp_next  = dec_exp;
                if (run_start) begin
                    start_pend_next = 1'b1;
                    first_ok_next   = first_piece_may_start_line;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg       <= '0;
            exp_reg        <= 2'd0;
            start_pend_reg <= 1'b0;
            first_ok_reg   <= 1'b0;
        end else begin
            part_reg       <= part_next;
            exp_reg        <= exp_next;
            start_pend_reg <= start_pend_next;
            first_ok_reg   <= first_ok_next;
        end
    end

endmodule

FILE: sv/ucbo_queue.sv
// Short first-in first-out queue between the decoder and the break logic.
// Depends on ucbo_pkg for the entry type.
module ucbo_queue #(
    parameter int DEPTH = ucbo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ucbo_pkg::cp_entry_t  push_data,
    input  logic                 pop,
    output ucbo_pkg::cp_entry_t  head,
    output logic                 not_empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ucbo_pkg::cp_entry_t store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head      = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/ucbo_back.sv
// Back end: piece and break-opportunity logic with the result register.
// Depends on ucbo_pkg; takes classified code points from ucbo_queue.
module ucbo_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ucbo_pkg::cp_entry_t          head,
    input  logic                         not_empty,
    output logic                         pop,
    output logic [ucbo_pkg::CP_W-1:0]    m_code_point,
    output logic                         m_is_space,
    output logic                         m_starts_piece,
    output logic                         m_piece_may_start_line,
    output logic                         m_last_of_run,
    output logic                         m_valid,
    input  logic                         m_ready
);

    // Previous character, kept only as the flags the break rule needs.
    logic prev_nz_reg, prev_nz_next;
    logic prev_cjk_reg, prev_cjk_next;
    logic prev_ne_reg, prev_ne_next;
    logic open_reg, open_next;
    logic nb_reg, nb_next;
    logic valid_reg, valid_next;

    logic [ucbo_pkg::CP_W-1:0] cp_reg;
    logic space_reg, starts_reg, may_reg, last_reg;

    logic pv0, pcjk0, pne0, open0, nb0, brk, open1, nb1, starts, may_start;

    assign pop = not_empty && (!valid_reg || m_ready);

    always_comb begin
        pv0   = head.run_start ? 1'b0 : prev_nz_reg;
        pcjk0 = head.run_start ? 1'b0 : prev_cjk_reg;
        pne0  = head.run_start ? 1'b0 : prev_ne_reg;
        open0 = head.run_start ? 1'b0 : open_reg;
        nb0   = head.run_start ? head.first_ok : nb_reg;

        brk = pv0 && (pcjk0 || head.is_cjk) && !head.no_start && !pne0;
        open1 = brk ? 1'b0 : open0;
        nb1   = brk ? 1'b1 : nb0;
        starts    = !head.is_space && !open1;
        may_start = starts && nb1;

        prev_nz_next  = prev_nz_reg;
        prev_cjk_next = prev_cjk_reg;
        prev_ne_next  = prev_ne_reg;
        open_next     = open_reg;
        nb_next       = nb_reg;
        valid_next    = valid_reg && !m_ready;
        if (pop) begin
            valid_next    = 1'b1;
            prev_nz_next  = head.non_null;
            prev_cjk_next = head.is_cjk;
            prev_ne_next  = head.no_end;
            if (head.is_space) begin
                open_next = 1'b0;
                nb_next   = 1'b1;
            end else begin
                open_next = 1'b1;
                nb_next   = nb1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_nz_reg  <= 1'b0;
            prev_cjk_reg <= 1'b0;
            prev_ne_reg  <= 1'b0;
            open_reg     <= 1'b0;
            nb_reg       <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            prev_nz_reg  <= prev_nz_next;
            prev_cjk_reg <= prev_cjk_next;
            prev_ne_reg  <= prev_ne_next;
            open_reg     <= open_next;
            nb_reg       <= nb_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cp_reg     <= head.code_point;
            space_reg  <= head.is_space;
            starts_reg <= starts;
            may_reg    <= may_start;
            last_reg   <= head.run_end;
        end
    end

    assign m_code_point           = cp_reg;
    assign m_is_space             = space_reg;
    assign m_starts_piece         = starts_reg;
    assign m_piece_may_start_line = may_reg;
    assign m_last_of_run          = last_reg;
    assign m_valid                = valid_reg;

endmodule

FILE: sv/ucbo_checker.sv
// Port-level checker for the UTF-8 CJK break opportunity block, bound to it.
// Depends on ucbo_pkg and utf8_cjk_break_opportunity_assert.svh.
`include "utf8_cjk_break_opportunity_assert.svh"

module ucbo_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_ready,
    input  logic [ucbo_pkg::CP_W-1:0]    m_code_point,
    input  logic                         m_is_space,
    input  logic                         m_starts_piece,
    input  logic                         m_piece_may_start_line,
    input  logic                         m_last_of_run,
    input  logic                         m_valid,
    input  logic                         m_ready
);

    // A waiting result request keeps its payload until it is taken.
    property p_result_held;
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_code_point) && $stable(m_last_of_run));
    endproperty

    // The line-start flag only accompanies a new piece.
    property p_may_start;
        (m_valid && (m_is_space || !m_starts_piece)) |-> !m_piece_may_start_line;
    endproperty

    `UCBO_ASSERT(a_result_held, p_result_held, "result request changed while stalled")
    `UCBO_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `UCBO_ASSERT(a_full_only_on_stall, !s_ready |-> m_valid, "input stalled with no result")
    `UCBO_ASSERT(a_may_start_needs_piece, p_may_start, "line start flag without a new piece")

endmodule

bind utf8_cjk_break_opportunity ucbo_checker u_checker (.*);
